FILE: hdl/multichannel_pulse_train_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Pulse train generator assertion macros
// Shared property forms for the top level checks.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH
`define MULTICHANNEL_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define MPTG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mptg_pkg.sv
// ----------------------------------------------------------------------------
// Pulse train generator package
// Item types, operation codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package mptg_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int NUM_CHANNELS       = 4;
  localparam int PHASE_BITS         = 16;
  localparam int ADD_BITS           = 8;
  localparam int CFG_BITS           = 16;
  localparam int CFG_INDEX_BITS     = 1;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_TICKS   = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_TICKS = 1'd1;

  localparam logic [CFG_BITS-1:0] HIGH_TICKS_RESET   = 16'd10;
  localparam logic [CFG_BITS-1:0] PERIOD_TICKS_RESET = 16'd20;

  typedef struct packed {
    logic [1:0]          operation;
    logic [ADD_BITS-1:0] add_start;
    logic [ADD_BITS-1:0] add_stop;
    logic [ADD_BITS-1:0] add_switch;
    logic [ADD_BITS-1:0] add_freq;
  } in_item_t;

  typedef struct packed {
    logic level_start;
    logic level_stop;
    logic level_switch;
    logic level_freq;
    logic running;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic add;
    logic clr;
  } chan_ctrl_t;

  typedef struct packed {
    logic level_next;
    logic busy_next;
    logic busy;
  } chan_stat_t;

endpackage

FILE: hdl/mptg_ifs.sv
// ----------------------------------------------------------------------------
// Pulse train generator channels
// Valid/ready interfaces for the input and result items.
// ----------------------------------------------------------------------------
interface mptg_in_if
  import mptg_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface mptg_out_if
  import mptg_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: hdl/mptg_channel.sv
// ----------------------------------------------------------------------------
// Pulse train channel
// Pending count, phase counter and output level of one channel.
// ----------------------------------------------------------------------------
module mptg_channel
  import mptg_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chan_ctrl_t            ctrl,
  input  logic [ADD_BITS-1:0]   add_count,
  input  logic [CFG_BITS-1:0]   high_ticks,
  input  logic [CFG_BITS-1:0]   period_ticks,
  output chan_stat_t            stat
);

  logic [COUNT_BITS-1:0] pending;
  logic [COUNT_BITS-1:0] pending_next;
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;
  logic [PHASE_BITS-1:0] phase_inc;
  logic                  level;
  logic                  level_next;
  logic [COUNT_BITS:0]   sum;
  logic                  stepping;

  assign sum       = {1'b0, pending} + {{(COUNT_BITS + 1 - ADD_BITS){1'b0}}, add_count};
  assign phase_inc = phase + {{(PHASE_BITS - 1){1'b0}}, 1'b1};
  assign stepping  = ctrl.tick && (pending != '0);

  always_comb begin
    pending_next = pending;
    phase_next   = phase;
    level_next   = level;
    priority if (ctrl.clr) begin
      pending_next = '0;
      phase_next   = '0;
      level_next   = 1'b0;
    end else if (ctrl.add) begin
      pending_next = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    end else if (stepping) begin
      if (!level && (phase < high_ticks)) begin
        level_next = 1'b1;
      end else if (level && (phase > high_ticks)) begin
        level_next = 1'b0;
      end
      if (phase_inc == period_ticks) begin
        phase_next   = '0;
        pending_next = pending - {{(COUNT_BITS - 1){1'b0}}, 1'b1};
      end else begin
        phase_next = phase_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      phase   <= '0;
      level   <= 1'b0;
    end else if (ctrl.load) begin
      pending <= pending_next;
      phase   <= phase_next;
      level   <= level_next;
    end
  end

  assign stat.level_next = level_next;
  assign stat.busy_next  = (pending_next != '0);
  assign stat.busy       = (pending != '0);

endmodule

FILE: hdl/multichannel_pulse_train_generator_top.sv
// ----------------------------------------------------------------------------
// Multichannel pulse train generator
// Four indicator channels driven by tick, add and clear items.
// ----------------------------------------------------------------------------
// One item is accepted per clock. All four channels update their pending
// count, phase counter and level at the accepting edge, and the result item
// (four levels and the running flag) is registered at that edge. The output
// register is the only buffer: input ready is high while it is empty or being
// emptied, so a steady one item per cycle flows as long as the result side
// takes items. The user must write high_ticks (index 0) and period_ticks (index
// 1) via the cfg port only while no item is in flight; unchecked by the block.
module multichannel_pulse_train_generator_top
  import mptg_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  mptg_in_if.sink                   in_ch,
  mptg_out_if.source                out_ch
);

  `include "multichannel_pulse_train_generator_top_assert.svh"

  logic [CFG_BITS-1:0]             high_ticks;
  logic [CFG_BITS-1:0]             period_ticks;
  logic                            active;
  logic                            active_next;
  logic                            accept;
  logic                            out_valid;
  out_item_t                       out_item;
  chan_ctrl_t                      ctrl;
  chan_stat_t [NUM_CHANNELS-1:0]   stat;
  logic [NUM_CHANNELS-1:0][ADD_BITS-1:0] add_counts;
  logic [NUM_CHANNELS-1:0]         busy_next;
  logic [NUM_CHANNELS-1:0]         busy_now;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_ticks   <= HIGH_TICKS_RESET;
      period_ticks <= PERIOD_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH_TICKS:   high_ticks   <= cfg_data;
        REG_PERIOD_TICKS: period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.load = accept;
    ctrl.tick = 1'b0;
    ctrl.add  = 1'b0;
    ctrl.clr  = 1'b0;
    unique case (in_ch.item.operation)
      OP_TICK:  ctrl.tick = active;
      OP_ADD:   ctrl.add  = 1'b1;
      OP_CLEAR: ctrl.clr  = 1'b1;
      default: ;
    endcase
  end

  assign add_counts[0] = in_ch.item.add_start;
  assign add_counts[1] = in_ch.item.add_stop;
  assign add_counts[2] = in_ch.item.add_switch;
  assign add_counts[3] = in_ch.item.add_freq;

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    mptg_channel #(
      .COUNT_BITS (COUNT_BITS)
    ) u_chan (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .add_count    (add_counts[c]),
      .high_ticks   (high_ticks),
      .period_ticks (period_ticks),
      .stat         (stat[c])
    );
    assign busy_next[c] = stat[c].busy_next;
    assign busy_now[c]  = stat[c].busy;
  end

  always_comb begin
    active_next = active;
    priority if (ctrl.clr) begin
      active_next = 1'b0;
    end else if (ctrl.add) begin
      active_next = 1'b1;
    end else if (ctrl.tick) begin
      active_next = |busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        active    <= active_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.level_start  <= stat[0].level_next;
      out_item.level_stop   <= stat[1].level_next;
      out_item.level_switch <= stat[2].level_next;
      out_item.level_freq   <= stat[3].level_next;
      out_item.running      <= active_next;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

  `MPTG_ASSERT_NOW(a_busy_implies_active, |busy_now, active,
    "pulses pending while inactive")
  `MPTG_ASSERT_NEXT(a_accept_gives_result, accept, out_ch.valid,
    "accepted item produced no result")
  `MPTG_ASSERT_NEXT(a_clear_stops, accept && (in_ch.item.operation == OP_CLEAR),
    !out_ch.item.running && !(|busy_now), "clear left state running")
  `MPTG_ASSERT_NEXT(a_add_runs, accept && (in_ch.item.operation == OP_ADD),
    out_ch.item.running && active, "add did not set running")

endmodule
